FILE: rtl/core/pva_pkg.sv
// Package for the priority voice allocator: sizes, operation, command and
// configuration codes, the result struct and controller/datapath interface structs.
// No dependencies.
package pva_pkg;

  localparam int Voices    = 32;
  localparam int SoundIds  = 1024;
  localparam int VoiceW    = 5;
  localparam int SoundW    = 10;

  localparam logic [2:0] OP_PLAY   = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_PURGE  = 3'd3;
  localparam logic [2:0] OP_GAIN   = 3'd4;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_STOP   = 3'd1;
  localparam logic [2:0] CMD_SETGN  = 3'd2;
  localparam logic [2:0] CMD_REJECT = 3'd3;
  localparam logic [2:0] CMD_DONE   = 3'd4;

  localparam logic [1:0] CFG_SOUND_VOL = 2'd0;
  localparam logic [1:0] CFG_MUSIC_VOL = 2'd1;
  localparam logic [1:0] CFG_TOP_PRIO  = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [VoiceW-1:0] voice;
    logic [SoundW-1:0] sound;
    logic [7:0]        gain;
    logic [7:0]        pan_right;
    logic              looping;
    logic [2:0]        speed_mode;
    logic              last;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic clr_scan;   // restart the voice index and chosen voice
    logic step;       // advance the voice index
    logic kill_cur;   // free the voice under the index
    logic claim;      // write the chosen voice with the request
    logic free_idx;   // free voice_index (voice finished)
    logic clr_all;    // purge: free the voice under the index
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       bad_req;   // play gain negative
    logic       one_flag;
    logic       cutoff;
    logic       cur_busy;
    logic       cur_match; // busy and same sound
    logic       last_idx;
    logic       have_chosen;
    logic       chosen_busy;
    logic       take;      // scan rule picks the current voice
  } dp_stat_t;

endpackage

FILE: rtl/core/pva_datapath.sv
// Datapath of the priority voice allocator: request capture, gain multiply,
// voice table, scan index and chosen-voice tracking. Uses pva_pkg.
module pva_datapath import pva_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          in_op,
  input  logic [SoundW-1:0]   in_sound,
  input  logic [7:0]          in_pan,
  input  logic [8:0]          in_att,
  input  logic [7:0]          in_flags,
  input  logic [15:0]         in_prio,
  input  logic [VoiceW-1:0]   in_vidx,
  input  logic [7:0]          sound_volume,
  input  logic [7:0]          music_volume,
  input  logic [15:0]         top_priority,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [VoiceW-1:0]   cur_voice,
  output logic [SoundW-1:0]   cur_sound,
  output logic [VoiceW-1:0]   chosen,
  output logic [SoundW-1:0]   chosen_sound,
  output logic [SoundW-1:0]   req_sound,
  output logic [7:0]          play_gain,
  output logic [7:0]          set_gain,
  output logic [7:0]          pan_r,
  output logic [7:0]          flags
);

  logic [2:0]          op;
  logic [SoundW-1:0]   snd;
  logic [7:0]          pan;
  logic [8:0]          att;
  logic [15:0]         prio;
  logic [VoiceW-1:0]   vidx;
  logic [VoiceW-1:0]   idx;
  logic                have;
  logic [15:0]         low;
  logic [Voices-1:0]   busy;
  logic [SoundW-1:0]   vsound [Voices];
  logic [15:0]         vprio  [Voices];
  logic [16:0]         prod;    // (att + 255) * scale, registered
  logic [16:0]         prod_sv; // with sound_volume, for change gain
  logic                att_neg;

  // att+255 is in -1..254 for att -256..-1, or above for non-negative att.
  logic signed [9:0]   base;
  logic [7:0]          scale;
  logic signed [18:0]  p;
  logic signed [18:0]  p_sv;
  logic signed [15:0]  eff_prio;

  assign base  = $signed({att[8], att}) + 10'sd255;
  assign scale = flags[0] ? music_volume : sound_volume;
  assign p     = base * $signed({1'b0, scale});
  assign p_sv  = base * $signed({1'b0, sound_volume});

  // Truncating divide by 255 of a non-negative product: v*257>>16 is at most
  // one below the quotient, and one compare corrects it. Saturates at 255.
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [25:0] m;
    logic [9:0]  d;
    logic [16:0] r;
    m = {9'd0, v} * 26'd257;
    d = m[25:16];
    r = v - {7'd0, d} * 17'd255;
    if (r >= 17'd255) d = d + 10'd1;
    div255 = (d > 10'd255) ? 8'd255 : d[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_op;
      snd   <= in_sound;
      pan   <= in_pan;
      att   <= in_att;
      flags <= in_flags;
      prio  <= in_prio;
      vidx  <= in_vidx;
    end
    // Product registered in the cycle after load; the controller waits in S_MUL.
    prod    <= p[18] ? 17'd0 : p[16:0];
    prod_sv <= p_sv[18] ? 17'd0 : p_sv[16:0];
    att_neg <= p[18] && (p < -19'sd254);
  end

  assign play_gain = div255(prod);
  assign set_gain  = div255(prod_sv);
  assign pan_r     = pan ^ 8'h80;
  assign req_sound = snd;
  assign eff_prio  = flags[3] ? $signed(top_priority) : $signed(prio);

  assign cur_voice = idx;
  assign cur_sound = vsound[idx];
  assign chosen_sound = vsound[chosen];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      idx  <= '0;
      have <= 1'b0;
    end else begin
      if (cmd.clr_scan) begin
        idx  <= '0;
        have <= 1'b0;
        low  <= eff_prio;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (stat.take && cmd.step) begin
        have   <= 1'b1;
        chosen <= idx;
        if (busy[idx]) low <= vprio[idx];
      end
      if (cmd.kill_cur || cmd.clr_all) begin
        busy[idx]  <= 1'b0;
        vprio[idx] <= '0;
      end
      if (cmd.free_idx) begin
        busy[vidx]  <= 1'b0;
        vprio[vidx] <= '0;
      end
      if (cmd.claim) begin
        busy[chosen]   <= 1'b1;
        vsound[chosen] <= snd;
        vprio[chosen]  <= eff_prio;
      end
    end
  end

  assign stat.op          = op;
  assign stat.bad_req     = att_neg;
  assign stat.one_flag    = flags[1];
  assign stat.cutoff      = flags[2];
  assign stat.cur_busy    = busy[idx];
  assign stat.cur_match   = busy[idx] && (vsound[idx] == snd);
  assign stat.last_idx    = (idx == VoiceW'(Voices - 1));
  assign stat.have_chosen = have;
  assign stat.chosen_busy = busy[chosen];
  assign stat.take        = !busy[idx] ||
                            ($signed(vprio[idx]) <= $signed(low)) ||
                            (!have && flags[2] && vsound[idx] == snd);

endmodule

FILE: rtl/core/pva_ctrl.sv
// Controller of the priority voice allocator: sequences scans and emits
// result transfers into a one-entry output register. Uses pva_pkg.
module pva_ctrl import pva_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output dp_cmd_t           cmd,
  input  dp_stat_t          stat,
  input  logic [VoiceW-1:0] cur_voice,
  input  logic [SoundW-1:0] cur_sound,
  input  logic [VoiceW-1:0] chosen,
  input  logic [SoundW-1:0] chosen_sound,
  input  logic [SoundW-1:0] req_sound,
  input  logic [7:0]        play_gain,
  input  logic [7:0]        set_gain,
  input  logic [7:0]        pan_r,
  input  logic [7:0]        flags,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_res
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_CHK1  = 10'b0000000100,
    S_CUT   = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_STEAL = 10'b0000100000,
    S_START = 10'b0001000000,
    S_LIST  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t  state, state_next;
  logic    any, any_next;   // a list result is held
  result_t res;
  logic    emit;
  logic    free_ok;
  result_t pend;            // final result of a request, sent from S_EMIT
  result_t held;            // newest list result, sent once the next is found or the list ends
  result_t found_res;
  logic    held_load;

  // Output register: a result is written only when it is empty or draining.
  assign free_ok = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    any_next   = any;
    cmd        = '0;
    emit       = 1'b0;
    res        = '0;
    in_ready   = 1'b0;
    held_load  = 1'b0;
    if (stat.op == OP_GAIN) begin
      found_res = '{CMD_SETGN, cur_voice, req_sound, set_gain, 8'd0, 1'b0, 3'd0, 1'b0};
    end else begin
      found_res = '{CMD_STOP, cur_voice, cur_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0};
    end
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.clr_scan = 1'b1;
        any_next     = 1'b0;
        state_next   = S_CHK1;
      end
      S_CHK1: begin
        cmd.clr_scan = 1'b1;
        case (stat.op)
          OP_PLAY: begin
            if (stat.bad_req) begin
              res = '{CMD_REJECT, '0, req_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1};
              state_next = S_EMIT;
            end else if (stat.one_flag) state_next = S_CUT;
            else state_next = S_SCAN;
          end
          OP_STOP, OP_PURGE, OP_GAIN: state_next = S_LIST;
          OP_FINISH: begin
            cmd.free_idx = 1'b1;
            state_next   = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CUT: begin
        if (stat.cur_match && !stat.cutoff) begin
          res = '{CMD_REJECT, '0, req_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1};
          state_next = S_EMIT;
        end else if (stat.cur_match) begin
          if (free_ok) begin
            emit = 1'b1;
            res  = '{CMD_STOP, cur_voice, cur_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0};
            cmd.kill_cur = 1'b1;
          end
        end else if (stat.last_idx) begin
          cmd.clr_scan = 1'b1;
          state_next   = S_SCAN;
        end else cmd.step = 1'b1;
      end
      S_SCAN: begin
        if (!stat.cur_busy) begin
          cmd.step   = 1'b1;
          state_next = S_STEAL;
        end else begin
          cmd.step = 1'b1;
          if (stat.last_idx) state_next = S_STEAL;
        end
      end
      S_STEAL: begin
        if (!stat.have_chosen) begin
          res = '{CMD_REJECT, '0, req_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1};
          state_next = S_EMIT;
        end else if (stat.chosen_busy) begin
          if (free_ok) begin
            emit = 1'b1;
            res  = '{CMD_STOP, chosen, chosen_sound, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0};
            state_next = S_START;
          end
        end else state_next = S_START;
      end
      S_START: begin
        res = '{CMD_START, chosen, req_sound, play_gain, pan_r, flags[4],
                flags[7:5], 1'b1};
        cmd.claim  = 1'b1;
        state_next = S_EMIT;
      end
      S_LIST: begin
        if (free_ok) begin
          // A found result is held back one find, so that the final one of
          // the list can leave with tlast set.
          if (stat.cur_match || (stat.op == OP_PURGE && stat.cur_busy)) begin
            emit      = any;
            res       = held;
            held_load = 1'b1;
            any_next  = 1'b1;
          end
          if (stat.op != OP_GAIN && (stat.cur_match || stat.op == OP_PURGE))
            cmd.kill_cur = 1'b1;
          cmd.step = 1'b1;
          if (stat.last_idx) state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (any) begin
          res      = held;
          res.last = 1'b1;
        end else begin
          res = '{CMD_DONE, '0, '0, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1};
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (free_ok) begin
          emit       = 1'b1;
          res        = pend;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      any       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      any   <= any_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res <= res;
    if (held_load) held <= found_res;
    if (state_next == S_EMIT && state != S_EMIT) pend <= res;
  end

endmodule

FILE: rtl/core/priority_voice_allocator.sv
// Top level of the priority voice allocator.
// Uses pva_pkg, pva_ctrl and pva_datapath.
//
// Usage: requests enter on the s_axis channel, one transfer per request.
// Configuration registers (sound volume, music volume, top priority) are
// written on the cfg channel while the block is idle. Each request yields
// one or more results on the m_axis channel; the final one has tlast high.
// An immediate reject is decided in S_CHK1 and written out from S_EMIT; the
// voice table is scanned one voice per cycle while results can be written
// (the index stays on a voice that a cutoff stops until it is freed), twice
// for a one-instance play. One request is processed at a time;
// s_axis_tready is high only between requests.
// Reset clears the voice table and loads the register reset values.
// A stalled receiver holds the output register, and the cutoff and list scans wait.
module priority_voice_allocator import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], sound_id[12:3], pan[20:13], attenuation[29:21],
  // play_flags[37:30], request_priority[53:38], voice_index[58:54]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command[2:0], voice[7:3], sound[17:8], gain[25:18], pan_right[33:26],
  // looping[34], speed_mode[37:35]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  sound_volume, music_volume;
  logic [15:0] top_priority;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [VoiceW-1:0] cur_voice, chosen;
  logic [SoundW-1:0] cur_sound, chosen_sound, req_sound;
  logic [7:0]  play_gain, set_gain, pan_r, flags;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_volume <= 8'd128;
      music_volume <= 8'd255;
      top_priority <= 16'h7fff;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOUND_VOL: sound_volume <= cfg_data[7:0];
        CFG_MUSIC_VOL: music_volume <= cfg_data[7:0];
        CFG_TOP_PRIO:  top_priority <= cfg_data;
        default: ;
      endcase
    end
  end

  pva_datapath u_dp (
    .clk, .rst,
    .in_op(s_axis_tdata[2:0]), .in_sound(s_axis_tdata[12:3]),
    .in_pan(s_axis_tdata[20:13]), .in_att(s_axis_tdata[29:21]),
    .in_flags(s_axis_tdata[37:30]), .in_prio(s_axis_tdata[53:38]),
    .in_vidx(s_axis_tdata[58:54]),
    .sound_volume, .music_volume, .top_priority,
    .cmd, .stat, .cur_voice, .cur_sound, .chosen, .chosen_sound,
    .req_sound, .play_gain, .set_gain, .pan_r, .flags
  );

  pva_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd, .stat, .cur_voice, .cur_sound, .chosen, .chosen_sound,
    .req_sound, .play_gain, .set_gain, .pan_r, .flags,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {2'b00, res.speed_mode, res.looping, res.pan_right,
                         res.gain, res.sound, res.voice, res.command};
  assign m_axis_tlast = res.last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res.command <= CMD_DONE) else $error("bad command");

endmodule
